// File: src/cba_pkg.sv
`timescale 1ns / 1ps

package cba_pkg;

  // Default sizing
  localparam int unsigned NUM_BLOCKS_DEF  = 32;
  localparam int unsigned BLOCK_UNITS_DEF = 4;
  localparam int unsigned OWNER_BITS_DEF  = 8;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_WRITE = 2'd2,
    ST_DONE  = 2'd3
  } state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] owner_id;
    logic [7:0] size_units;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] start_block;
    logic [5:0] blocks_changed;
    logic [5:0] free_count;
  } rsp_t;

endpackage

// File: src/contiguous_block_allocator_top.sv
// First-fit contiguous block allocator.
// Request word (in_valid_i/in_ready_o/in_data_i): opcode, owner id, size in units.
//   Allocate claims the lowest run of ceil(size/BLOCK_UNITS) free blocks for the
//   owner, query searches the same way without claiming, free releases every
//   block the owner holds. Owner 0, size 0 on allocate/query and opcode 3 give
//   ok=0 and change nothing.
// Response word (out_valid_o/out_ready_i/out_data_o): ok, start block, blocks
//   changed and the free count after the request. One response per request.
// Scan: one block table read per cycle through a registered read port, so a free
//   or a failed search reads every block before its response; a search that hits
//   stops at the block that completes the run. An allocate then writes its run,
//   one block per cycle, before its response. A refused request goes from idle
//   straight to the done state, which loads its response into the output register.
// Throughput: one request in flight; in_ready_o is high only when idle, from
//   the cycle after the response word is loaded.
// The response sits in an output register, so a new request is taken while the
//   previous response waits; a stalled receiver holds the finished result in
//   the sequencer until the output register empties.
// Reset: asynchronous, active low. Every block reads free at once (per-block
//   valid flags are cleared), free count returns to NUM_BLOCKS.
`timescale 1ns / 1ps

module contiguous_block_allocator_top #(
  parameter int unsigned NUM_BLOCKS  = cba_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned BLOCK_UNITS = cba_pkg::BLOCK_UNITS_DEF,
  parameter int unsigned OWNER_BITS  = cba_pkg::OWNER_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cba_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cba_pkg::rsp_t out_data_o
);

  localparam int unsigned IdxW  = $clog2(NUM_BLOCKS);
  localparam int unsigned CntW  = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned ProdW = CntW + 8;  // run * BLOCK_UNITS and size both fit

  cba_pkg::state_e state_q, state_d;

  // request context
  logic                  alloc_q, free_mode_q;
  logic [OWNER_BITS-1:0] owner_q;
  logic [7:0]            size_q;

  // scan pipeline: issue pointer, then registered table read
  logic [CntW-1:0]       iss_q;
  logic                  pend_q;
  logic [IdxW-1:0]       proc_idx_q;
  logic [OWNER_BITS-1:0] rd_own_q;
  logic                  rd_vld_q;

  logic [CntW-1:0]       run_q;
  logic                  ok_q;
  logic [IdxW-1:0]       start_q;
  logic [CntW-1:0]       chg_q;
  logic [CntW-1:0]       free_total_q;

  logic [IdxW-1:0]       wr_ptr_q;
  logic [CntW-1:0]       wr_left_q;

  // block table: owner store plus per-block valid flags (unset reads free)
  logic [NUM_BLOCKS-1:0] blk_vld_q;
  logic [OWNER_BITS-1:0] owner_mem [NUM_BLOCKS];

  cba_pkg::rsp_t         out_q;
  logic                  out_valid_q;

  // ---------------------------------------------------------------- request decode
  logic                    accept;
  logic [OWNER_BITS+7:0]   owner_wide;
  logic [OWNER_BITS-1:0]   req_owner;
  logic                    owner_ok, req_free, req_find;

  assign accept     = in_valid_i && in_ready_o;
  assign owner_wide = {{OWNER_BITS{1'b0}}, in_data_i.owner_id};
  assign req_owner  = owner_wide[OWNER_BITS-1:0];
  assign owner_ok   = (req_owner != '0);
  assign req_free   = owner_ok && (in_data_i.opcode == cba_pkg::OP_FREE);
  assign req_find   = owner_ok && (in_data_i.size_units != 8'd0) &&
                      ((in_data_i.opcode == cba_pkg::OP_ALLOC) ||
                       (in_data_i.opcode == cba_pkg::OP_QUERY));

  // ---------------------------------------------------------------- scan datapath
  // run covers the request once run * BLOCK_UNITS reaches the size, so the run
  // length at the hit is the block count needed
  logic [OWNER_BITS-1:0] cur_own;
  logic [CntW-1:0]       run_nx;
  logic [CntW-1:0]       start_full;
  logic [ProdW-1:0]      run_units;
  logic                  hit, match, scan_done;

  assign cur_own    = rd_vld_q ? rd_own_q : '0;
  assign run_nx     = (cur_own == '0) ? run_q + CntW'(1) : '0;
  assign run_units  = ProdW'(run_nx) * ProdW'(BLOCK_UNITS);
  assign hit        = (state_q == cba_pkg::ST_SCAN) && pend_q && !free_mode_q &&
                      (run_units >= ProdW'(size_q));
  assign match      = pend_q && free_mode_q && (cur_own == owner_q);
  assign start_full = CntW'(proc_idx_q) + CntW'(1) - run_nx;
  assign scan_done  = (iss_q == CntW'(NUM_BLOCKS)) && !pend_q;

  // ---------------------------------------------------------------- sequencer
  logic rd_issue, wr_en, load_out;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cba_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (req_free || req_find) ? cba_pkg::ST_SCAN : cba_pkg::ST_DONE;
        end
      end
      cba_pkg::ST_SCAN: begin
        if (hit) begin
          state_d = alloc_q ? cba_pkg::ST_WRITE : cba_pkg::ST_DONE;
        end else if (scan_done) begin
          state_d = cba_pkg::ST_DONE;
        end
      end
      cba_pkg::ST_WRITE: begin
        if (wr_left_q == CntW'(1)) begin
          state_d = cba_pkg::ST_DONE;
        end
      end
      cba_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = cba_pkg::ST_IDLE;
        end
      end
      default: state_d = cba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == cba_pkg::ST_IDLE);
    rd_issue   = (state_q == cba_pkg::ST_SCAN) && (iss_q != CntW'(NUM_BLOCKS));
    wr_en      = (state_q == cba_pkg::ST_WRITE);
    load_out   = (state_q == cba_pkg::ST_DONE) && (!out_valid_q || out_ready_i);
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cba_pkg::ST_IDLE;
      pend_q       <= 1'b0;
      free_total_q <= CntW'(NUM_BLOCKS);
      blk_vld_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= rd_issue;
      if (match) begin
        blk_vld_q[proc_idx_q] <= 1'b0;
        free_total_q          <= free_total_q + CntW'(1);
      end
      if (hit && alloc_q) begin
        free_total_q <= free_total_q - run_nx;
      end
      if (wr_en) begin
        blk_vld_q[wr_ptr_q] <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- table store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      owner_mem[wr_ptr_q] <= owner_q;
    end
    if (rd_issue) begin
      rd_own_q <= owner_mem[iss_q[IdxW-1:0]];
      rd_vld_q <= blk_vld_q[iss_q[IdxW-1:0]];
    end
  end

  // ---------------------------------------------------------------- payload regs
  logic [CntW+5:0] free_wide, chg_wide;
  logic [IdxW+4:0] start_wide;

  assign free_wide  = {6'd0, free_total_q};
  assign chg_wide   = {6'd0, chg_q};
  assign start_wide = {5'd0, start_q};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      alloc_q     <= (in_data_i.opcode == cba_pkg::OP_ALLOC);
      free_mode_q <= req_free;
      owner_q     <= req_owner;
      size_q      <= in_data_i.size_units;
      ok_q        <= req_free;
      start_q     <= '0;
      chg_q       <= '0;
      iss_q       <= '0;
      run_q       <= '0;
    end
    if (rd_issue) begin
      iss_q      <= iss_q + CntW'(1);
      proc_idx_q <= iss_q[IdxW-1:0];
    end
    if (pend_q) begin
      run_q <= run_nx;
    end
    if (match) begin
      chg_q <= chg_q + CntW'(1);
    end
    if (hit) begin
      ok_q      <= 1'b1;
      start_q   <= start_full[IdxW-1:0];
      wr_ptr_q  <= start_full[IdxW-1:0];
      wr_left_q <= run_nx;
      if (alloc_q) begin
        chg_q <= run_nx;
      end
    end
    if (wr_en) begin
      wr_ptr_q  <= wr_ptr_q + IdxW'(1);
      wr_left_q <= wr_left_q - CntW'(1);
    end
    if (load_out) begin
      out_q.ok             <= ok_q;
      out_q.start_block    <= start_wide[4:0];
      out_q.blocks_changed <= chg_wide[5:0];
      out_q.free_count     <= free_wide[5:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/cba_checker.sv
`timescale 1ns / 1ps

module cba_assert (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input cba_pkg::req_t in_data_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input cba_pkg::rsp_t out_data_i
);

  // held response word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("response word changed while stalled");

  // one request at a time: busy right after taking a word
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

  a_fail_nochg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.ok |-> out_data_i.blocks_changed == 6'd0)
    else $error("failed request reports changed blocks");

  a_fail_nostart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.ok |-> out_data_i.start_block == 5'd0)
    else $error("failed request reports a start block");

endmodule

bind contiguous_block_allocator_top cba_assert u_cba_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
